@@ rtl/rau_pkg.sv @@
package rau_pkg;

   localparam int OperandWidth = 16;
   localparam int ProdWidth    = 2 * OperandWidth;
   localparam int SumWidth     = ProdWidth + 1;
   localparam int CntWidth     = $clog2(SumWidth + 1);
   localparam int ResNumWidth  = 33;
   localparam int ResDenWidth  = 31;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   // Command and status between the sequencer and the divider.
   typedef struct packed {
      logic                start;
      logic [SumWidth-1:0] dividend;
      logic [SumWidth-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                done;
      logic [SumWidth-1:0] quotient;
      logic [SumWidth-1:0] remainder;
   } div_rsp_type;

endpackage

@@ rtl/rau_divider.sv @@
module rau_divider
   import rau_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_rsp_type rsp
);

   logic [SumWidth-1:0] quo_ff, quo_in;
   logic [SumWidth-1:0] rem_ff, rem_in;
   logic [SumWidth-1:0] dsr_ff, dsr_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [SumWidth:0]   trial;

   // One restoring quotient bit per cycle, most significant first.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[SumWidth-1]} - {1'b0, dsr_ff};
      if (cmd.start) begin
         quo_in  = cmd.dividend;
         rem_in  = '0;
         dsr_in  = cmd.divisor;
         cnt_in  = CntWidth'(SumWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[SumWidth]) begin
            rem_in = trial[SumWidth-1:0];
            quo_in = {quo_ff[SumWidth-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[SumWidth-2:0], quo_ff[SumWidth-1]};
            quo_in = {quo_ff[SumWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

@@ rtl/rational_arithmetic_unit.sv @@
// Rational arithmetic unit: a request carries two signed 16-bit fractions and an operation
// (add, subtract, multiply, divide); the response is the exact result in lowest terms with
// the sign on the numerator and a positive denominator. A zero denominator or a division by
// a zero fraction sets error and returns 0/1. One request is handled at a time: the cross
// products are formed and summed, then a single 33-bit restoring divider (one quotient
// bit per cycle) runs Euclid's algorithm on the magnitudes, at least one step, and finally
// divides numerator and denominator by the common divisor. Error requests skip the products
// and the divider, and zero results skip the divider. req_stall is high from acceptance
// until the response leaves.
module rational_arithmetic_unit
   import rau_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_operation,
   input  logic signed [OperandWidth-1:0] req_a_num,
   input  logic signed [OperandWidth-1:0] req_a_den,
   input  logic signed [OperandWidth-1:0] req_b_num,
   input  logic signed [OperandWidth-1:0] req_b_den,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [ResNumWidth-1:0] rsp_res_num,
   output logic [ResDenWidth-1:0]        rsp_res_den,
   output logic                          rsp_error
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_PROD  = 8'b00000010,
      ST_SUM   = 8'b00000100,
      ST_GCD   = 8'b00001000,
      ST_DIVN  = 8'b00010000,
      ST_DIVD  = 8'b00100000,
      ST_WAIT  = 8'b01000000,
      ST_RESP  = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]              op_ff, op_in;
   logic [OperandWidth-1:0] anm_ff, anm_in, adm_ff, adm_in, bnm_ff, bnm_in, bdm_ff, bdm_in;
   logic                    ans_ff, ans_in, ads_ff, ads_in, bns_ff, bns_in, bds_ff, bds_in;
   logic [ProdWidth-1:0]    p1_ff, p1_in, p2_ff, p2_in, dm_ff, dm_in;
   logic                    p1s_ff, p1s_in, p2s_ff, p2s_in, ds_ff, ds_in;
   logic [SumWidth-1:0]     nm_ff, nm_in, x_ff, x_in, y_ff, y_in, g_ff, g_in;
   logic                    ns_ff, ns_in, pend_ff, pend_in;
   logic [SumWidth-1:0]     onum_ff, onum_in;
   logic [ProdWidth-1:0]    oden_ff, oden_in;
   logic                    oerr_ff, oerr_in;
   div_cmd_type             dcmd;
   div_rsp_type             drsp;
   logic [SumWidth-1:0]     rn_mag;

   // Magnitude of a two's complement operand (the most negative value maps onto itself).
   function automatic logic [OperandWidth-1:0] mag_of(input logic [OperandWidth-1:0] v);
      mag_of = v[OperandWidth-1] ? (~v + 1'b1) : v;
   endfunction

   rau_divider u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (dcmd),
      .rsp   (drsp)
   );

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      anm_in = anm_ff; adm_in = adm_ff; bnm_in = bnm_ff; bdm_in = bdm_ff;
      ans_in = ans_ff; ads_in = ads_ff; bns_in = bns_ff; bds_in = bds_ff;
      p1_in = p1_ff; p2_in = p2_ff; dm_in = dm_ff;
      p1s_in = p1s_ff; p2s_in = p2s_ff; ds_in = ds_ff;
      nm_in = nm_ff; ns_in = ns_ff; x_in = x_ff; y_in = y_ff; g_in = g_ff;
      pend_in = pend_ff;
      onum_in = onum_ff; oden_in = oden_ff; oerr_in = oerr_ff;
      dcmd = '0;
      rn_mag = '0;
      unique case (state_ff)
         // Capture operands in sign-magnitude form.
         ST_IDLE: begin
            if (req_valid) begin
               op_in  = req_operation;
               anm_in = mag_of(req_a_num); ans_in = req_a_num[OperandWidth-1];
               adm_in = mag_of(req_a_den); ads_in = req_a_den[OperandWidth-1];
               bnm_in = mag_of(req_b_num); bns_in = req_b_num[OperandWidth-1];
               bdm_in = mag_of(req_b_den); bds_in = req_b_den[OperandWidth-1];
               state_in = ST_PROD;
            end
         end
         // Error check, then cross products; subtraction flips the sign of b.
         ST_PROD: begin
            if (adm_ff == '0 || bdm_ff == '0 || (op_ff == OP_DIV && bnm_ff == '0)) begin
               onum_in = '0; oden_in = ProdWidth'(1); oerr_in = 1'b1;
               state_in = ST_RESP;
            end else begin
               oerr_in = 1'b0;
               case (op_ff)
                  OP_MUL: begin
                     p1_in = anm_ff * bnm_ff; p1s_in = ans_ff ^ bns_ff;
                     p2_in = '0;              p2s_in = 1'b0;
                     dm_in = adm_ff * bdm_ff; ds_in  = ads_ff ^ bds_ff;
                  end
                  OP_DIV: begin
                     p1_in = anm_ff * bdm_ff; p1s_in = ans_ff ^ bds_ff;
                     p2_in = '0;              p2s_in = 1'b0;
                     dm_in = adm_ff * bnm_ff; ds_in  = ads_ff ^ bns_ff;
                  end
                  default: begin
                     p1_in = anm_ff * bdm_ff; p1s_in = ans_ff ^ bds_ff;
                     p2_in = bnm_ff * adm_ff;
                     p2s_in = bns_ff ^ ads_ff ^ (op_ff == OP_SUB);
                     dm_in = adm_ff * bdm_ff; ds_in  = ads_ff ^ bds_ff;
                  end
               endcase
               state_in = ST_SUM;
            end
         end
         // Signed-magnitude sum, then start Euclid unless the sum is zero.
         ST_SUM: begin
            if (p1s_ff == p2s_ff) begin
               nm_in = {1'b0, p1_ff} + {1'b0, p2_ff}; ns_in = p1s_ff;
            end else if (p1_ff >= p2_ff) begin
               nm_in = {1'b0, p1_ff - p2_ff}; ns_in = p1s_ff;
            end else begin
               nm_in = {1'b0, p2_ff - p1_ff}; ns_in = p2s_ff;
            end
            if (nm_in == '0) begin
               onum_in = '0; oden_in = ProdWidth'(1);
               state_in = ST_RESP;
            end else begin
               x_in = nm_in;
               y_in = {1'b0, dm_ff};
               pend_in = 1'b0;
               state_in = ST_GCD;
            end
         end
         // Euclid: x, y <- y, x mod y on the shared divider.
         ST_GCD: begin
            if (!pend_ff) begin
               if (y_ff == '0) begin
                  g_in = x_ff;
                  dcmd.start = 1'b1; dcmd.dividend = nm_ff; dcmd.divisor = x_ff;
                  state_in = ST_DIVN;
               end else begin
                  dcmd.start = 1'b1; dcmd.dividend = x_ff; dcmd.divisor = y_ff;
                  pend_in = 1'b1;
               end
            end else if (drsp.done) begin
               x_in = y_ff;
               y_in = drsp.remainder;
               pend_in = 1'b0;
            end
         end
         // Reduced numerator.
         ST_DIVN: begin
            if (drsp.done) begin
               rn_mag = drsp.quotient;
               onum_in = (ns_ff ^ ds_ff) ? (~rn_mag + 1'b1) : rn_mag;
               dcmd.start = 1'b1; dcmd.dividend = {1'b0, dm_ff}; dcmd.divisor = g_ff;
               state_in = ST_DIVD;
            end
         end
         ST_DIVD: begin
            if (drsp.done) begin
               oden_in = drsp.quotient[ProdWidth-1:0];
               state_in = ST_RESP;
            end
         end
         ST_WAIT: state_in = ST_RESP;
         ST_RESP: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      anm_ff <= anm_in; adm_ff <= adm_in; bnm_ff <= bnm_in; bdm_ff <= bdm_in;
      ans_ff <= ans_in; ads_ff <= ads_in; bns_ff <= bns_in; bds_ff <= bds_in;
      p1_ff <= p1_in; p2_ff <= p2_in; dm_ff <= dm_in;
      p1s_ff <= p1s_in; p2s_ff <= p2s_in; ds_ff <= ds_in;
      nm_ff <= nm_in; ns_ff <= ns_in; x_ff <= x_in; y_ff <= y_in; g_ff <= g_in;
      onum_ff <= onum_in; oden_ff <= oden_in; oerr_ff <= oerr_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = (state_ff == ST_RESP);
   assign rsp_res_num = onum_ff;
   assign rsp_res_den = oden_ff[ResDenWidth-1:0];
   assign rsp_error   = oerr_ff;

   // A response with an error always carries 0/1.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_res_num == '0 && rsp_res_den == ResDenWidth'(1))
      else $error("error response not 0/1");

   // A non-error response has a nonzero denominator.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_error |-> rsp_res_den != '0)
      else $error("zero denominator in response");

   // The divider only finishes while the sequencer waits on it.
   assert property (@(posedge clock) disable iff (reset)
      drsp.done |-> state_ff == ST_GCD || state_ff == ST_DIVN || state_ff == ST_DIVD)
      else $error("divider result with no consumer");

endmodule

@@ tb/sv/rau_checker.sv @@
module rau_checker
   import rau_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [1:0]                     req_operation,
   input  logic signed [OperandWidth-1:0] req_a_num,
   input  logic signed [OperandWidth-1:0] req_a_den,
   input  logic signed [OperandWidth-1:0] req_b_num,
   input  logic signed [OperandWidth-1:0] req_b_den,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic signed [ResNumWidth-1:0]  rsp_res_num,
   input  logic [ResDenWidth-1:0]         rsp_res_den,
   input  logic                           rsp_error,
   output int                             fail_count,
   output int                             pending_count
);

   typedef struct packed {
      logic [ResNumWidth-1:0] num;
      logic [ResDenWidth-1:0] den;
      logic                   error;
   } fraction_type;

   // Predictions waiting for their responses, kept in request order.
   fraction_type pred_mem[16];
   int           put_count;
   int           take_count;

   function automatic longint unsigned euclid(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   // Exact fraction result on signed 64-bit values, then reduced.
   function automatic fraction_type reduce_fraction(op_type op, longint an, longint ad,
                                                    longint bn, longint bd);
      fraction_type r;
      longint n, d;
      longint unsigned nm, dm, g;
      logic neg;
      r = '{num: '0, den: 1, error: 1'b0};
      if (ad == 0 || bd == 0 || (op == OP_DIV && bn == 0)) begin
         r.error = 1'b1;
         return r;
      end
      case (op)
         OP_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
         OP_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
         OP_MUL: begin n = an * bn; d = ad * bd; end
         default: begin n = an * bd; d = ad * bn; end
      endcase
      if (n == 0) return r;
      neg = (n < 0) != (d < 0);
      nm = (n < 0) ? -n : n;
      dm = (d < 0) ? -d : d;
      g = euclid(nm, dm);
      nm = nm / g;
      dm = dm / g;
      r.num = ResNumWidth'(neg ? -nm : nm);
      r.den = ResDenWidth'(dm);
      return r;
   endfunction

   assign pending_count = put_count - take_count;

   always @(posedge clock) begin
      fraction_type want, got;
      if (reset) begin
         fail_count <= 0;
         put_count  <= 0;
         take_count <= 0;
      end else begin
         // Predict each accepted request.
         if (req_valid && !req_stall) begin
            pred_mem[put_count[3:0]] <= reduce_fraction(op_type'(req_operation), req_a_num,
                                                         req_a_den, req_b_num, req_b_den);
            put_count <= put_count + 1;
         end
         // Compare each accepted response with the oldest prediction.
         if (rsp_valid && !rsp_stall) begin
            got = '{num: rsp_res_num, den: rsp_res_den, error: rsp_error};
            if (put_count == take_count) begin
               $display("%0t: unexpected response %0d/%0d err %0b", $time,
                        rsp_res_num, rsp_res_den, rsp_error);
               fail_count <= fail_count + 1;
            end else begin
               want = pred_mem[take_count[3:0]];
               take_count <= take_count + 1;
               if (got !== want) begin
                  $display("%0t: expected %0d/%0d err %0b, actual %0d/%0d err %0b", $time,
                           $signed(want.num), want.den, want.error,
                           rsp_res_num, rsp_res_den, rsp_error);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

@@ tb/sv/tb_rational_arithmetic_unit.sv @@
module tb_rational_arithmetic_unit
   import rau_pkg::*;
();

   localparam int RandomCount = 1440;
   localparam int CycleLimit  = 10000000;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic [1:0]                     req_operation;
   logic signed [OperandWidth-1:0] req_a_num;
   logic signed [OperandWidth-1:0] req_a_den;
   logic signed [OperandWidth-1:0] req_b_num;
   logic signed [OperandWidth-1:0] req_b_den;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic signed [ResNumWidth-1:0]  rsp_res_num;
   logic [ResDenWidth-1:0]         rsp_res_den;
   logic                           rsp_error;
   int                             fail_count;
   int                             pending_count;
   int                             cycle_count;

   rational_arithmetic_unit dut (.*);
   rau_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run watchdog.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // The receiver stalls in random runs of its own.
   initial rsp_stall = 1'b0;
   always @(posedge clock) begin
      if (cycle_count % 512 < 128) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 3) == 0);
   end

   function automatic logic [OperandWidth-1:0] random_operand();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return OperandWidth'($urandom_range(0, 2) - 1);
         3: return OperandWidth'($urandom_range(0, 30) - 15);
         default: return OperandWidth'($urandom);
      endcase
   endfunction

   // Present one request and hold it until accepted.
   task automatic send_request(op_type op, logic [OperandWidth-1:0] an,
                               logic [OperandWidth-1:0] ad, logic [OperandWidth-1:0] bn,
                               logic [OperandWidth-1:0] bd);
      req_valid <= 1'b1;
      req_operation <= op;
      req_a_num <= an;
      req_a_den <= ad;
      req_b_num <= bn;
      req_b_den <= bd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic sender_gap();
      if ($urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   endtask

   initial begin
      op_type op;
      int burst;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_ADD;
      req_a_num = '0;
      req_a_den = 16'sd1;
      req_b_num = '0;
      req_b_den = 16'sd1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: each operation, extremes, zero denominators, divide by zero, zero result.
      for (int k = 0; k < 4; k++) begin
         op = op_type'(k);
         send_request(op, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
         send_request(op, 16'sh7fff, -16'sd1, 16'sh8000, 16'sd1);
         send_request(op, 16'sd3, 16'sd0, 16'sd2, 16'sd5);
         send_request(op, 16'sd0, 16'sd7, 16'sd0, -16'sd9);
         send_request(op, -16'sd6, -16'sd4, 16'sd9, 16'sh8000);
      end
      send_request(OP_DIV, 16'sd5, 16'sd2, 16'sd0, 16'sd3);
      send_request(OP_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd0);
      send_request(OP_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2);

      // Random: bursts, sometimes with gaps between them.
      for (int k = 0; k < RandomCount; k += burst) begin
         burst = $urandom_range(1, 12);
         for (int j = 0; j < burst; j++)
            send_request(op_type'($urandom_range(0, 3)), random_operand(),
                         ($urandom_range(0, 19) == 0) ? '0 : random_operand(),
                         random_operand(),
                         ($urandom_range(0, 19) == 0) ? '0 : random_operand());
         sender_gap();
      end
      req_valid <= 1'b0;

      // Let the last prediction register before draining.
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (1000) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
